FILE: rtl/core/gre_pkg.sv
package gre_pkg;

    localparam int MAX_MARKERS = 4096;
    localparam int MARK_W      = 12;
    localparam int PERS_W      = 6;
    localparam int CNT_W       = 13;
    localparam int GENO_AW     = MARK_W + PERS_W;
    localparam int DIVD_W      = 68;
    localparam int DIVS_W      = 44;
    localparam int SUM_W       = 50;
    localparam int VSUM_W      = 45;
    localparam int V_W         = 33;
    localparam int INV_W       = 32;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_MARKERS);
    localparam logic [1:0]       GENO_MISSING = 2'b10;
    localparam logic             REG_METHOD = 1'b0;
    localparam logic             REG_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        ACT_FREQ  = 2'd0,
        ACT_GENO  = 2'd1,
        ACT_QUERY = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LMUL,
        S_LDIV,
        S_LWAIT,
        S_LSAT,
        S_QRD,
        S_QDAT,
        S_QTERM,
        S_QMUL,
        S_QACC,
        S_QFIN,
        S_QDIV,
        S_QOUT
    } t_state;

    typedef struct packed {
        logic signed [V_W-1:0]   v;
        logic signed [INV_W-1:0] inv;
        logic                    flip;
        logic [15:0]             freq;
    } t_marker;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [1:0] dosage(input logic [1:0] bits, input logic flip);
        logic [1:0] n;
        n = {1'b0, bits[1]} + {1'b0, bits[0]};
        return flip ? (2'd2 - n) : n;
    endfunction

endpackage

FILE: rtl/core/genomic_relationship_entry.sv
// Genotype load writes the store on accept. Frequency load: multiply, 68-step divide (skipped
// for a zero product), saturating store write. Query: each marker is read; a used marker adds a
// term step, in method 0 also a multiply and accumulate; a final 68-step divide runs if needed.
// One item at a time (o_ready only when idle), using the shared multiplier and radix-2 divider.
// Reset: synchronous active-low; method 0, marker_count 4096; stores are undefined until written.
module genomic_relationship_entry (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [11:0] i_marker_index,
    input  logic [5:0]  i_first_person,
    input  logic [5:0]  i_second_person,
    input  logic [15:0] i_frequency,
    input  logic        i_flip,
    input  logic [1:0]  i_genotype_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_relation,
    output logic [12:0] o_markers_used,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gre_pkg::t_state r_state, n_state;

    logic                        r_method;
    logic [12:0]                 r_count;
    logic                        r_out_valid;
    logic signed [31:0]          r_relation;
    logic [12:0]                 r_markers_used;

    logic [11:0]                 r_mi;
    logic [5:0]                  r_p1, r_p2;
    logic [15:0]                 r_fq;
    logic                        r_fl;
    logic                        r_diag;
    logic [12:0]                 r_k;
    logic [12:0]                 r_used;
    logic signed [gre_pkg::SUM_W-1:0]  r_sum;
    logic signed [gre_pkg::VSUM_W-1:0] r_vsum;
    logic [63:0]                 r_prod;
    logic                        r_neg;
    logic                        r_x1;
    logic signed [gre_pkg::V_W-1:0]    r_v;
    logic signed [31:0]          r_inv;
    logic signed [34:0]          r_term;
    logic [gre_pkg::DIVD_W-1:0]  r_q;

    logic                        accept;
    logic                        cfg_we;
    logic [12:0]                 n_lim;
    logic                        rd_en;
    logic [1:0]                  geno_a, geno_b;
    gre_pkg::t_marker            mark;
    gre_pkg::t_marker            mark_wdata;
    logic                        mark_we;
    logic [1:0]                  x, y;
    logic                        miss;
    logic signed [17:0]          c1, c2;
    logic signed [17:0]          c1_neg, c2_neg;
    logic [31:0]                 mul_a, mul_b;
    logic [63:0]                 mul_p;
    logic signed [16:0]          fv;
    logic signed [16:0]          fv_neg;
    logic signed [34:0]          t_mag, t_sgn, term;
    logic signed [34:0]          term_neg;
    logic [31:0]                 term_mag;
    logic [31:0]                 inv_mag;
    logic [64:0]                 rnd;
    logic [35:0]                 q_acc;
    logic signed [gre_pkg::SUM_W-1:0] q_s;
    logic [gre_pkg::SUM_W-1:0]   sum_mag;
    logic signed [gre_pkg::V_W-1:0] v_s;
    logic signed [69:0]          q70, wide;
    logic signed [31:0]          sat_val;
    logic                        m0_div, m1_div;
    gre_pkg::t_div_req           div_req;
    gre_pkg::t_div_rsp           div_rsp;

    assign accept  = i_valid & o_ready;
    assign o_ready = (r_state == gre_pkg::S_IDLE);
    assign cfg_we  = psel & penable & pwrite & pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == gre_pkg::REG_COUNT) ? {19'd0, r_count} : {31'd0, r_method};
    assign n_lim   = (r_count > gre_pkg::COUNT_RESET) ? gre_pkg::COUNT_RESET : r_count;

    assign o_valid        = r_out_valid;
    assign o_relation     = r_relation;
    assign o_markers_used = r_markers_used;

    gre_store u_store (
        .i_clk          (i_clk),
        .i_geno_we      (accept && (i_action == gre_pkg::ACT_GENO)),
        .i_geno_waddr   ({i_first_person, i_marker_index}),
        .i_geno_wdata   (i_genotype_bits),
        .i_rd_en        (rd_en),
        .i_geno_raddr_a ({r_p1, r_k[11:0]}),
        .i_geno_raddr_b ({r_p2, r_k[11:0]}),
        .o_geno_a       (geno_a),
        .o_geno_b       (geno_b),
        .i_mark_we      (mark_we),
        .i_mark_waddr   (r_mi),
        .i_mark_wdata   (mark_wdata),
        .i_mark_raddr   (r_k[11:0]),
        .o_mark         (mark)
    );

    gre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        x      = gre_pkg::dosage(geno_a, mark.flip);
        y      = gre_pkg::dosage(geno_b, mark.flip);
        miss   = (geno_a == gre_pkg::GENO_MISSING) || (geno_b == gre_pkg::GENO_MISSING);
        c1     = $signed({2'b00, x, 14'd0}) - $signed({2'b00, mark.freq});
        c2     = $signed({2'b00, y, 14'd0}) - $signed({2'b00, mark.freq});
        c1_neg = -c1;
        c2_neg = -c2;
        fv     = 17'sd32768 - $signed({1'b0, r_fq});
        fv_neg = -fv;

        t_mag    = $signed({2'b00, r_prod[32:0]});
        t_sgn    = r_neg ? -t_mag : t_mag;
        term     = t_sgn - ((r_diag && r_x1) ? 35'sd268435456 : 35'sd0);
        term_neg = -r_term;
        term_mag = r_term[34] ? term_neg[31:0] : r_term[31:0];
        inv_mag  = r_inv[31] ? (32'd0 - 32'(r_inv)) : 32'(r_inv);

        rnd   = r_diag ? (({1'b0, r_prod} + 65'd268435456) >> 29)
                       : (({1'b0, r_prod} + 65'd134217728) >> 28);
        q_acc = rnd[35:0];
        q_s   = r_neg ? -$signed({14'd0, q_acc}) : $signed({14'd0, q_acc});

        sum_mag = r_sum[gre_pkg::SUM_W-1] ? (gre_pkg::SUM_W'(0) - gre_pkg::SUM_W'(r_sum))
                                          : gre_pkg::SUM_W'(r_sum);
        v_s     = r_neg ? -$signed({1'b0, r_prod[31:0]}) : $signed({1'b0, r_prod[31:0]});

        q70  = $signed({2'b00, r_q});
        wide = (r_neg ? -q70 : q70) + (r_diag ? 70'sd65536 : 70'sd0);
        if (wide > 70'sd2147483647) begin
            sat_val = 32'sh7FFFFFFF;
        end else if (wide < -70'sd2147483648) begin
            sat_val = 32'sh80000000;
        end else begin
            sat_val = wide[31:0];
        end

        m0_div = !r_method && (r_used != 13'd0);
        m1_div = r_method && !r_vsum[gre_pkg::VSUM_W-1] && (r_vsum != '0);
    end

    always_comb begin
        case (r_state)
            gre_pkg::S_LMUL: begin
                mul_a = {16'd0, r_fq};
                mul_b = {15'd0, (fv[16] ? fv_neg : fv)};
            end
            gre_pkg::S_QMUL: begin
                mul_a = term_mag;
                mul_b = inv_mag;
            end
            default: begin
                mul_a = {15'd0, (c1[17] ? c1_neg[16:0] : c1[16:0])};
                mul_b = {15'd0, (c2[17] ? c2_neg[16:0] : c2[16:0])};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        n_state              = r_state;
        rd_en                = 1'b0;
        mark_we              = 1'b0;
        mark_wdata.v         = r_v;
        mark_wdata.inv       = sat_val;
        mark_wdata.flip      = r_fl;
        mark_wdata.freq      = r_fq;
        div_req.start        = 1'b0;
        div_req.dividend     = (gre_pkg::DIVD_W'(1) << 45) + gre_pkg::DIVD_W'(r_prod[31:1]);
        div_req.divisor      = gre_pkg::DIVS_W'(r_prod[31:0]);
        case (r_state)
            gre_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        gre_pkg::ACT_FREQ:  n_state = gre_pkg::S_LMUL;
                        gre_pkg::ACT_QUERY: n_state = gre_pkg::S_QRD;
                        default:            n_state = gre_pkg::S_IDLE;
                    endcase
                end
            end
            gre_pkg::S_LMUL: n_state = gre_pkg::S_LDIV;
            gre_pkg::S_LDIV: begin
                if (r_prod[31:0] == 32'd0) begin
                    n_state = gre_pkg::S_LSAT;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = gre_pkg::S_LWAIT;
                end
            end
            gre_pkg::S_LWAIT: begin
                if (div_rsp.done) begin
                    n_state = gre_pkg::S_LSAT;
                end
            end
            gre_pkg::S_LSAT: begin
                mark_we = 1'b1;
                n_state = gre_pkg::S_IDLE;
            end
            gre_pkg::S_QRD: begin
                if (r_k >= n_lim) begin
                    n_state = gre_pkg::S_QFIN;
                end else begin
                    rd_en   = 1'b1;
                    n_state = gre_pkg::S_QDAT;
                end
            end
            gre_pkg::S_QDAT:  n_state = miss ? gre_pkg::S_QRD : gre_pkg::S_QTERM;
            gre_pkg::S_QTERM: n_state = r_method ? gre_pkg::S_QRD : gre_pkg::S_QMUL;
            gre_pkg::S_QMUL:  n_state = gre_pkg::S_QACC;
            gre_pkg::S_QACC:  n_state = gre_pkg::S_QRD;
            gre_pkg::S_QFIN: begin
                if (m0_div) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = gre_pkg::DIVD_W'(sum_mag) + gre_pkg::DIVD_W'(r_used[12:1]);
                    div_req.divisor  = gre_pkg::DIVS_W'(r_used);
                    n_state          = gre_pkg::S_QDIV;
                end else if (m1_div) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = (gre_pkg::DIVD_W'(sum_mag) << (r_diag ? 16 : 17))
                                     + gre_pkg::DIVD_W'(r_vsum[gre_pkg::DIVS_W-1:1]);
                    div_req.divisor  = r_vsum[gre_pkg::DIVS_W-1:0];
                    n_state          = gre_pkg::S_QDIV;
                end else begin
                    n_state = gre_pkg::S_QOUT;
                end
            end
            gre_pkg::S_QDIV: begin
                if (div_rsp.done) begin
                    n_state = gre_pkg::S_QOUT;
                end
            end
            gre_pkg::S_QOUT: begin
                if (!r_out_valid || i_ready) begin
                    n_state = gre_pkg::S_IDLE;
                end
            end
            default: n_state = gre_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gre_pkg::S_IDLE;
            r_method    <= 1'b0;
            r_count     <= gre_pkg::COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_we) begin
                if (paddr[2] == gre_pkg::REG_METHOD) begin
                    r_method <= pwdata[0];
                end else begin
                    r_count <= pwdata[12:0];
                end
            end
            if (r_state == gre_pkg::S_QOUT && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            gre_pkg::S_IDLE: begin
                if (accept) begin
                    r_mi   <= i_marker_index;
                    r_p1   <= i_first_person;
                    r_p2   <= i_second_person;
                    r_fq   <= i_frequency;
                    r_fl   <= i_flip;
                    r_diag <= (i_action == gre_pkg::ACT_QUERY) && (i_first_person == i_second_person);
                    r_k    <= '0;
                    r_used <= '0;
                    r_sum  <= '0;
                    r_vsum <= '0;
                end
            end
            gre_pkg::S_LMUL: begin
                r_prod <= mul_p;
                r_neg  <= fv[16];
            end
            gre_pkg::S_LDIV: begin
                r_v <= v_s;
                r_q <= '0;
            end
            gre_pkg::S_LWAIT: begin
                if (div_rsp.done) begin
                    r_q <= div_rsp.quotient;
                end
            end
            gre_pkg::S_QDAT: begin
                if (miss) begin
                    r_k <= r_k + 13'd1;
                end else begin
                    r_prod <= mul_p;
                    r_neg  <= c1[17] ^ c2[17];
                    r_x1   <= (x == 2'd1);
                    r_v    <= mark.v;
                    r_inv  <= mark.inv;
                end
            end
            gre_pkg::S_QTERM: begin
                r_term <= term;
                if (r_method) begin
                    r_sum  <= r_sum + gre_pkg::SUM_W'(term);
                    r_vsum <= r_vsum + gre_pkg::VSUM_W'(r_v);
                    r_used <= r_used + 13'd1;
                    r_k    <= r_k + 13'd1;
                end
            end
            gre_pkg::S_QMUL: begin
                r_prod <= mul_p;
                r_neg  <= r_term[34] ^ r_inv[31];
            end
            gre_pkg::S_QACC: begin
                r_sum  <= r_sum + q_s;
                r_used <= r_used + 13'd1;
                r_k    <= r_k + 13'd1;
            end
            gre_pkg::S_QFIN: begin
                r_neg <= r_sum[gre_pkg::SUM_W-1];
                r_q   <= '0;
            end
            gre_pkg::S_QDIV: begin
                if (div_rsp.done) begin
                    r_q <= div_rsp.quotient;
                end
            end
            gre_pkg::S_QOUT: begin
                if (!r_out_valid || i_ready) begin
                    r_relation     <= sat_val;
                    r_markers_used <= r_used;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/core/gre_div.sv
module gre_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gre_pkg::t_div_req i_req,
    output gre_pkg::t_div_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [6:0]                  r_cnt;
    logic [gre_pkg::DIVS_W:0]    r_rem;
    logic [gre_pkg::DIVD_W-1:0]  r_quo;
    logic [gre_pkg::DIVS_W-1:0]  r_div;
    logic [gre_pkg::DIVS_W:0]    rem_sh;
    logic [gre_pkg::DIVS_W:0]    diff;
    logic                        ge;

    assign rem_sh = {r_rem[gre_pkg::DIVS_W-1:0], r_quo[gre_pkg::DIVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign diff   = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt == 7'(gre_pkg::DIVD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff : rem_sh;
            r_quo <= {r_quo[gre_pkg::DIVD_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: rtl/core/gre_store.sv
module gre_store (
    input  logic                         i_clk,
    input  logic                         i_geno_we,
    input  logic [gre_pkg::GENO_AW-1:0]  i_geno_waddr,
    input  logic [1:0]                   i_geno_wdata,
    input  logic                         i_rd_en,
    input  logic [gre_pkg::GENO_AW-1:0]  i_geno_raddr_a,
    input  logic [gre_pkg::GENO_AW-1:0]  i_geno_raddr_b,
    output logic [1:0]                   o_geno_a,
    output logic [1:0]                   o_geno_b,
    input  logic                         i_mark_we,
    input  logic [gre_pkg::MARK_W-1:0]   i_mark_waddr,
    input  gre_pkg::t_marker             i_mark_wdata,
    input  logic [gre_pkg::MARK_W-1:0]   i_mark_raddr,
    output gre_pkg::t_marker             o_mark
);

    logic [1:0]       r_geno [0:(1 << gre_pkg::GENO_AW)-1];
    gre_pkg::t_marker r_mark [0:gre_pkg::MAX_MARKERS-1];

    always_ff @(posedge i_clk) begin
        if (i_geno_we) begin
            r_geno[i_geno_waddr] <= i_geno_wdata;
        end
        if (i_rd_en) begin
            o_geno_a <= r_geno[i_geno_raddr_a];
            o_geno_b <= r_geno[i_geno_raddr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mark_we) begin
            r_mark[i_mark_waddr] <= i_mark_wdata;
        end
        if (i_rd_en) begin
            o_mark <= r_mark[i_mark_raddr];
        end
    end

endmodule
